// ----- rtl/bce_pkg.sv -----
// bce_pkg: shared types and constants for the bounded cycle enumerator
// used by bce_adj_mem and bounded_cycle_enumerator
`default_nettype none
package bce_pkg;

  localparam int unsigned MaxVertices = 1024;
  localparam int unsigned MaxCycleLen = 7;
  localparam int unsigned VidW        = $clog2(MaxVertices);

  typedef struct packed {
    logic            op;
    logic [VidW-1:0] edge_source;
    logic [VidW-1:0] edge_target;
  } bce_in_t;

  typedef struct packed {
    logic            cycle_found;
    logic            search_done;
    logic [2:0]      cycle_length;
    logic [VidW-1:0] vertex_a;
    logic [VidW-1:0] vertex_b;
    logic [VidW-1:0] vertex_c;
    logic [VidW-1:0] vertex_d;
    logic [VidW-1:0] vertex_e;
    logic [VidW-1:0] vertex_f;
    logic [VidW-1:0] vertex_g;
  } bce_out_t;

  localparam logic OpLoad = 1'b0;
  localparam logic OpNext = 1'b1;

  localparam logic [0:0] RegVertexCount = 1'b0;

endpackage
`default_nettype wire

// ----- rtl/bounded_cycle_enumerator.sv -----
// bounded_cycle_enumerator: top level, search sequencer, path stack and apb registers
// needs bce_pkg and bce_adj_mem
`default_nettype none
// usage
//   start_i with busy_o low hands in one transaction; op load writes one edge
//   into the adjacency matrix, op next advances the depth-first search to the
//   next simple cycle of 3..MaxCycleLen vertices or reports search_done
//   each transaction yields exactly one result, shown for one cycle with
//   done_o high; the receiver cannot stall it
//   a load is answered the cycle after it is taken and busy_o stays low
//   a next request keeps busy_o high while it scans adjacency bits (address,
//   registered read, decide), pushes or pops, opens a start vertex and
//   probes the closing edge at the deepest level, plus the step that takes it; the
//   result follows in the cycle after the deciding step, so the busy time depends
//   on the graph and only one request is in flight at a time
//   after reset the block sweeps the whole matrix clear, one bit a cycle,
//   with busy_o high; apb writes are taken throughout. a load or a
//   vertex_count write restarts the search at 0 at once; on-path checks
//   compare against the path stack itself
//   vertex_count sits at apb addresses 0 and 1 (only paddr[1] is decoded)
module bounded_cycle_enumerator
  import bce_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire bce_in_t     in_i,
  output logic             done_o,
  output bce_out_t         out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned VW  = VidW;
  localparam int unsigned CW  = VW + 1;
  localparam int unsigned AW  = 2 * VW;
  localparam int unsigned DW  = 3;

  typedef enum logic [7:0] {
    StClr    = 8'b00000001,
    StIdle   = 8'b00000010,
    StBegin  = 8'b00000100,
    StScan   = 8'b00001000,
    StWait   = 8'b00010000,
    StDecide = 8'b00100000,
    StClose  = 8'b01000000,
    StCloseD = 8'b10000000
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    vcount_q, vcount_d;
  logic [AW:0]      clr_q, clr_d;
  logic [CW-1:0]    n_lim;
  logic [VW-1:0]    path_q [MaxCycleLen];
  logic [VW-1:0]    path_d [MaxCycleLen];
  logic [CW-1:0]    cur_q  [MaxCycleLen];
  logic [CW-1:0]    cur_d  [MaxCycleLen];
  logic [DW-1:0]    dep_q, dep_d;
  logic [CW-1:0]    sv_q, sv_d;
  logic             fin_q, fin_d;
  logic             act_q, act_d;
  logic [CW-1:0]    c_q, c_d;
  logic [VW-1:0]    adj_q, adj_d;
  bce_out_t         res_q, res_d;
  logic             done_q, done_d;
  logic             closew_q;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic             wdata, rbit;
  logic             cfg_wr;
  logic             accept;
  logic             restart;
  logic             on_path;
  logic [VW-1:0]    cur_v;
  logic [VW-1:0]    sv_v;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[1:1] == RegVertexCount) ? {{(32-CW){1'b0}}, vcount_q} : 32'd0;
  assign n_lim  = (vcount_q > CW'(MaxVertices)) ? CW'(MaxVertices) : vcount_q;

  bce_adj_mem #(.AddrW(AW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rbit)
  );

  assign accept  = start_i & ~busy_o;
  assign restart = (cfg_wr && paddr[1:1] == RegVertexCount) || (accept && in_i.op == OpLoad);
  assign cur_v   = path_q[dep_q];
  assign sv_v    = sv_q[VW-1:0];

  // a candidate is on the path when it matches a stacked vertex above the start
  always_comb begin
    on_path = 1'b0;
    for (int i = 1; i < MaxCycleLen; i++) begin
      if (DW'(i) <= dep_q && path_q[i] == c_q[VW-1:0]) on_path = 1'b1;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = {in_i.edge_source, in_i.edge_target};
    wdata = 1'b1;
    if (state_q == StClr) begin
      we    = 1'b1;
      waddr = clr_q[AW-1:0];
      wdata = 1'b0;
    end else if (accept && in_i.op == OpLoad) begin
      we = 1'b1;
    end
    if (state_q == StClose || state_q == StCloseD)
      raddr = {adj_q, sv_v};
    else
      raddr = {cur_v, c_q[VW-1:0]};
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;
  assign out_o  = res_q;

  // search sequencer: matrix clear after reset, then adjacency bits probed through scan, wait and decide states
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    vcount_d = vcount_q;
    path_d   = path_q;
    cur_d    = cur_q;
    dep_d    = dep_q;
    sv_d     = sv_q;
    fin_d    = fin_q;
    act_d    = act_q;
    c_d      = c_q;
    adj_d    = adj_q;
    res_d    = res_q;
    done_d   = 1'b0;
    case (state_q)
      StClr: begin
        clr_d = clr_q + 1'b1;
        if (clr_q[AW]) state_d = StIdle;
      end
      StIdle: begin
        if (accept) begin
          res_d = '0;
          if (in_i.op == OpLoad) done_d = 1'b1;
          else state_d = StBegin;
        end
      end
      StBegin: begin
        if (fin_q) begin
          res_d.search_done = 1'b1;
          done_d = 1'b1;
          state_d = StIdle;
        end else if (!act_q) begin
          if (sv_q >= n_lim) begin
            fin_d = 1'b1;
            res_d.search_done = 1'b1;
            done_d = 1'b1;
            state_d = StIdle;
          end else begin
            dep_d = '0;
            path_d[0] = sv_v;
            cur_d[0] = '0;
            act_d = 1'b1;
          end
        end else begin
          c_d = cur_q[dep_q];
          state_d = StScan;
        end
      end
      StScan: begin
        if (c_q >= n_lim) begin
          // row exhausted: pop
          cur_d[dep_q] = c_q;
          if (dep_q == '0) begin
            act_d = 1'b0;
            sv_d = sv_q + 1'b1;
          end else begin
            dep_d = dep_q - 1'b1;
          end
          state_d = StBegin;
        end else begin
          state_d = StWait;
        end
      end
      StWait: state_d = StDecide;
      StDecide: begin
        adj_d = c_q[VW-1:0];
        c_d = c_q + 1'b1;
        state_d = StScan;
        if (rbit) begin
          if (c_q[VW-1:0] == sv_v && dep_q > 3'd1) begin
            cur_d[dep_q] = c_q + 1'b1;
            res_d.cycle_found = 1'b1;
            res_d.cycle_length = dep_q + 3'd1;
            res_d.vertex_a = path_q[0];
            res_d.vertex_b = path_q[1];
            res_d.vertex_c = path_q[2];
            res_d.vertex_d = (dep_q >= 3'd3) ? path_q[3] : '0;
            res_d.vertex_e = (dep_q >= 3'd4) ? path_q[4] : '0;
            res_d.vertex_f = (dep_q >= 3'd5) ? path_q[5] : '0;
            res_d.vertex_g = (dep_q >= 3'd6) ? path_q[6] : '0;
            done_d = 1'b1;
            state_d = StIdle;
          end else if (!on_path && c_q > sv_q) begin
            if (dep_q < DW'(MaxCycleLen - 2)) begin
              cur_d[dep_q] = c_q + 1'b1;
              dep_d = dep_q + 1'b1;
              path_d[dep_q + 1'b1] = c_q[VW-1:0];
              cur_d[dep_q + 1'b1] = '0;
              state_d = StBegin;
            end else begin
              state_d = StClose;
            end
          end
        end
      end
      // closing edge probe: address held in StClose, registered read data used in StCloseD
      StClose: state_d = closew_q ? StCloseD : StClose;
      StCloseD: begin
        if (rbit) begin
          cur_d[dep_q] = c_q;
          res_d.cycle_found = 1'b1;
          res_d.cycle_length = dep_q + 3'd2;
          res_d.vertex_a = path_q[0];
          res_d.vertex_b = path_q[1];
          res_d.vertex_c = (dep_q == 3'd1) ? adj_q : path_q[2];
          res_d.vertex_d = (dep_q == 3'd2) ? adj_q : (dep_q > 3'd2) ? path_q[3] : '0;
          res_d.vertex_e = (dep_q == 3'd3) ? adj_q : (dep_q > 3'd3) ? path_q[4] : '0;
          res_d.vertex_f = (dep_q == 3'd4) ? adj_q : (dep_q > 3'd4) ? path_q[5] : '0;
          res_d.vertex_g = (dep_q == 3'd5) ? adj_q : '0;
          done_d = 1'b1;
          state_d = StIdle;
        end else begin
          state_d = StScan;
        end
      end
      default: state_d = StIdle;
    endcase
    if (cfg_wr && paddr[1:1] == RegVertexCount) vcount_d = pwdata[CW-1:0];
    if (restart) begin
      dep_d = '0;
      sv_d  = '0;
      fin_d = 1'b0;
      act_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClr;
      clr_q    <= '0;
      vcount_q <= '0;
      dep_q    <= '0;
      sv_q     <= '0;
      fin_q    <= 1'b0;
      act_q    <= 1'b0;
      c_q      <= '0;
      adj_q    <= '0;
      res_q    <= '0;
      done_q   <= 1'b0;
      closew_q <= 1'b0;
      for (int i = 0; i < MaxCycleLen; i++) begin
        path_q[i] <= '0;
        cur_q[i]  <= '0;
      end
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      vcount_q <= vcount_d;
      path_q   <= path_d;
      cur_q    <= cur_d;
      dep_q    <= dep_d;
      sv_q     <= sv_d;
      fin_q    <= fin_d;
      act_q    <= act_d;
      c_q      <= c_d;
      adj_q    <= adj_d;
      res_q    <= res_d;
      done_q   <= done_d;
      closew_q <= (state_q == StClose) && !closew_q;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bce_adj_mem.sv -----
// bce_adj_mem: adjacency bit matrix, one bit per (source, target) pair
// one write port, one registered read port; needs bce_pkg
`default_nettype none
module bce_adj_mem
  import bce_pkg::*;
#(
  parameter int unsigned AddrW = 20
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic             wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic                  rdata_o
);

  logic mem_q [2**AddrW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire
